FILE: hw/rtl/cbs_pkg.sv
package cbs_pkg;

   // fixed field widths
   localparam int COORD_BITS = 16;
   localparam int CNT_BITS = 6;
   localparam int MIN_INTERVALS = 2;
   localparam int MAX_INTERVALS = 63;

   // t in q0.16, the point at t equal to one is taken from the end point
   localparam int T_BITS = 16;

   // restoring division of 2^16 by n, one quotient bit a step
   localparam int DIV_STEPS = T_BITS + 1;
   localparam int STEP_BITS = 5;
   localparam int QUOT_BITS = T_BITS;

   // horner datapath widths
   localparam int A_W = COORD_BITS + 3;
   localparam int B_W = COORD_BITS + 4;
   localparam int C_W = COORD_BITS + 4;
   localparam int M1_W = C_W + T_BITS + 1;
   localparam int H1_W = B_W + T_BITS + 2;
   localparam int LO1_W = 24;
   localparam int HI1_W = H1_W - LO1_W;
   localparam int P1_W = LO1_W + T_BITS;
   localparam int H2_W = H1_W + T_BITS;
   localparam int LO2_W = 27;
   localparam int HI2_W = H2_W - LO2_W;
   localparam int P2_W = LO2_W + T_BITS;
   localparam int S_W = H2_W + T_BITS;
   localparam int FRAC_BITS = 3 * T_BITS;

   // datapath latency of one point through a lane
   localparam int PIPE_DEPTH = 6;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [CNT_BITS-1:0] count_type;
   typedef logic [T_BITS-1:0] t_type;

   // one segment with its precomputed step of t
   typedef struct packed {
      coord_type p0_x;
      coord_type p0_y;
      coord_type c0_x;
      coord_type c0_y;
      coord_type c1_x;
      coord_type c1_y;
      coord_type p1_x;
      coord_type p1_y;
      count_type n;
      logic [QUOT_BITS-1:0] quot;
      count_type remd;
   } seg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIV,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_DRAIN
   } back_state_type;

endpackage

FILE: hw/rtl/cbs_front.sv
module cbs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cbs_pkg::coord_type    req_start_x,
   input  cbs_pkg::coord_type    req_start_y,
   input  cbs_pkg::coord_type    req_ctrl_a_x,
   input  cbs_pkg::coord_type    req_ctrl_a_y,
   input  cbs_pkg::coord_type    req_ctrl_b_x,
   input  cbs_pkg::coord_type    req_ctrl_b_y,
   input  cbs_pkg::coord_type    req_end_x,
   input  cbs_pkg::coord_type    req_end_y,
   input  cbs_pkg::count_type    req_sample_count,
   input  cbs_pkg::qstat_type    q_stat,
   output logic                  q_push,
   output cbs_pkg::seg_type      q_wdata
);

   cbs_pkg::front_state_type state_ff, state_in;
   cbs_pkg::seg_type seg_ff, seg_in;
   logic [cbs_pkg::CNT_BITS-1:0] rem_ff, rem_in;
   // quotient of 2^16 by n of two or more fits in 16 bits
   logic [cbs_pkg::QUOT_BITS-1:0] quo_ff, quo_in;
   logic [cbs_pkg::STEP_BITS-1:0] step_ff, step_in;

   cbs_pkg::count_type n_sat;
   logic [cbs_pkg::CNT_BITS:0] rem_sh;
   logic div_bit;

   // clamp the interval count
   always_comb begin
      n_sat = req_sample_count;
      if (req_sample_count < cbs_pkg::CNT_BITS'(cbs_pkg::MIN_INTERVALS)) begin
         n_sat = cbs_pkg::CNT_BITS'(cbs_pkg::MIN_INTERVALS);
      end else if (req_sample_count >= cbs_pkg::CNT_BITS'(cbs_pkg::MAX_INTERVALS)) begin
         n_sat = cbs_pkg::CNT_BITS'(cbs_pkg::MAX_INTERVALS);
      end
   end

   // dividend is 2^16: only its top bit is set
   assign div_bit = (step_ff == cbs_pkg::STEP_BITS'(cbs_pkg::DIV_STEPS - 1));
   assign rem_sh = {rem_ff, div_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbs_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      seg_ff <= seg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
   end

   // accept, divide, hand over to the queue
   always_comb begin
      state_in = state_ff;
      seg_in = seg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      q_push = 1'b0;
      busy = 1'b1;
      q_wdata = seg_ff;
      q_wdata.quot = quo_ff;
      q_wdata.remd = rem_ff;
      unique case (state_ff)
         cbs_pkg::FRONT_IDLE: begin
            busy = 1'b0;
            if (start) begin
               seg_in.p0_x = req_start_x;
               seg_in.p0_y = req_start_y;
               seg_in.c0_x = req_ctrl_a_x;
               seg_in.c0_y = req_ctrl_a_y;
               seg_in.c1_x = req_ctrl_b_x;
               seg_in.c1_y = req_ctrl_b_y;
               seg_in.p1_x = req_end_x;
               seg_in.p1_y = req_end_y;
               seg_in.n = n_sat;
               rem_in = '0;
               quo_in = '0;
               step_in = cbs_pkg::STEP_BITS'(cbs_pkg::DIV_STEPS - 1);
               state_in = cbs_pkg::FRONT_DIV;
            end
         end
         cbs_pkg::FRONT_DIV: begin
            if (rem_sh >= {1'b0, seg_ff.n}) begin
               rem_in = cbs_pkg::CNT_BITS'(rem_sh - {1'b0, seg_ff.n});
               quo_in = {quo_ff[cbs_pkg::QUOT_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[cbs_pkg::CNT_BITS-1:0];
               quo_in = {quo_ff[cbs_pkg::QUOT_BITS-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = cbs_pkg::FRONT_PUSH;
            end
         end
         cbs_pkg::FRONT_PUSH: begin
            if (!q_stat.full) begin
               q_push = 1'b1;
               state_in = cbs_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = cbs_pkg::FRONT_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/cbs_queue.sv
module cbs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cbs_pkg::seg_type    wdata,
   input  logic                pop,
   output cbs_pkg::seg_type    rdata,
   output cbs_pkg::qstat_type  stat
);

   cbs_pkg::seg_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = entry_ff[rd_ptr_ff];
   assign stat.full = count_ff[1];
   assign stat.empty = (count_ff == '0);

endmodule

FILE: hw/rtl/cbs_lane.sv
module cbs_lane (
   input  logic                clock,
   input  logic                load,
   input  cbs_pkg::coord_type  p0,
   input  cbs_pkg::coord_type  c0,
   input  cbs_pkg::coord_type  c1,
   input  cbs_pkg::coord_type  p1,
   input  cbs_pkg::t_type      t,
   input  logic                last_s5,
   output cbs_pkg::coord_type  point
);

   // power-basis coefficients of the segment
   logic signed [cbs_pkg::A_W-1:0] a_ff, a_in, a_d;
   logic signed [cbs_pkg::B_W-1:0] b_ff, b_in, b_d;
   logic signed [cbs_pkg::C_W-1:0] c_ff, c_in, c_d;
   cbs_pkg::coord_type p0_ff, p1_ff;

   cbs_pkg::t_type t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   logic signed [cbs_pkg::M1_W-1:0] m1_ff, m1_in;
   logic signed [cbs_pkg::H1_W-1:0] h1_ff, h1_in;
   logic [cbs_pkg::P1_W-1:0] plo1_ff, plo1_in;
   logic signed [cbs_pkg::HI1_W-1:0] hi1_ff;
   logic signed [cbs_pkg::H2_W-1:0] h2_ff, h2_in;
   logic [cbs_pkg::P2_W-1:0] plo2_ff, plo2_in;
   logic signed [cbs_pkg::HI2_W-1:0] hi2_ff;
   logic signed [cbs_pkg::S_W-1:0] sum_s6;
   cbs_pkg::coord_type point_ff, point_in;

   // coefficients: a = 3(c0-p0), b = 3(p0-2c0+c1), c = p1-p0+3(c0-c1)
   always_comb begin
      a_d = cbs_pkg::A_W'(c0) - cbs_pkg::A_W'(p0);
      a_in = (a_d <<< 1) + a_d;
      b_d = cbs_pkg::B_W'(p0) - (cbs_pkg::B_W'(c0) <<< 1) + cbs_pkg::B_W'(c1);
      b_in = (b_d <<< 1) + b_d;
      c_d = cbs_pkg::C_W'(c0) - cbs_pkg::C_W'(c1);
      c_in = cbs_pkg::C_W'(p1) - cbs_pkg::C_W'(p0) + (c_d <<< 1) + c_d;
   end

   // horner, stage 1 and 2: h1 = c*t + b*2^16
   assign m1_in = cbs_pkg::M1_W'(c_ff) * cbs_pkg::M1_W'($signed({1'b0, t}));
   assign h1_in = cbs_pkg::H1_W'(m1_ff) + (cbs_pkg::H1_W'(b_ff) <<< cbs_pkg::T_BITS);

   // stage 3 and 4: h2 = h1*t + a*2^32, product cut in two halves
   assign plo1_in = cbs_pkg::P1_W'(h1_ff[cbs_pkg::LO1_W-1:0]) * cbs_pkg::P1_W'(t2_ff);
   assign h2_in = ((cbs_pkg::H2_W'(hi1_ff) * cbs_pkg::H2_W'($signed({1'b0, t3_ff})))
                   <<< cbs_pkg::LO1_W)
                  + $signed(cbs_pkg::H2_W'(plo1_ff))
                  + (cbs_pkg::H2_W'(a_ff) <<< (2 * cbs_pkg::T_BITS));

   // stage 5 and 6: h2*t + p0*2^48 + half, then keep the integer bits
   assign plo2_in = cbs_pkg::P2_W'(h2_ff[cbs_pkg::LO2_W-1:0]) * cbs_pkg::P2_W'(t4_ff);
   assign sum_s6 = ((cbs_pkg::S_W'(hi2_ff) * cbs_pkg::S_W'($signed({1'b0, t5_ff})))
                    <<< cbs_pkg::LO2_W)
                   + $signed(cbs_pkg::S_W'(plo2_ff))
                   + (cbs_pkg::S_W'(1) <<< (cbs_pkg::FRAC_BITS - 1))
                   + (cbs_pkg::S_W'(p0_ff) <<< cbs_pkg::FRAC_BITS);

   // the end point at t equal to one is exact
   assign point_in = last_s5
                     ? p1_ff
                     : sum_s6[cbs_pkg::FRAC_BITS+cbs_pkg::COORD_BITS-1:cbs_pkg::FRAC_BITS];

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         p0_ff <= p0;
         p1_ff <= p1;
      end
      t1_ff <= t;
      t2_ff <= t1_ff;
      t3_ff <= t2_ff;
      t4_ff <= t3_ff;
      t5_ff <= t4_ff;
      m1_ff <= m1_in;
      h1_ff <= h1_in;
      plo1_ff <= plo1_in;
      hi1_ff <= h1_ff[cbs_pkg::H1_W-1:cbs_pkg::LO1_W];
      h2_ff <= h2_in;
      plo2_ff <= plo2_in;
      hi2_ff <= h2_ff[cbs_pkg::H2_W-1:cbs_pkg::LO2_W];
      point_ff <= point_in;
   end

   assign point = point_ff;

endmodule

FILE: hw/rtl/cbs_back.sv
module cbs_back (
   input  logic                clock,
   input  logic                reset,
   input  cbs_pkg::qstat_type  q_stat,
   input  cbs_pkg::seg_type    q_head,
   output logic                q_pop,
   output logic                rsp_strobe,
   output cbs_pkg::coord_type  rsp_point_x,
   output cbs_pkg::coord_type  rsp_point_y,
   output logic                rsp_last_point
);

   cbs_pkg::back_state_type state_ff, state_in;
   cbs_pkg::count_type n_ff, n_in;
   logic [cbs_pkg::QUOT_BITS-1:0] quot_ff, quot_in;
   cbs_pkg::count_type remd_ff, remd_in;
   cbs_pkg::count_type k_ff, k_in;
   cbs_pkg::t_type t_ff, t_in;
   cbs_pkg::count_type r_ff, r_in;
   cbs_pkg::ctl_type ctl_pipe_ff [cbs_pkg::PIPE_DEPTH];
   cbs_pkg::ctl_type issue;

   logic [cbs_pkg::CNT_BITS:0] r_sum;
   logic pipe_busy;

   // points still inside the lanes that read the coefficients
   always_comb begin
      pipe_busy = 1'b0;
      for (int i = 0; i < cbs_pkg::PIPE_DEPTH - 1; i++) begin
         pipe_busy = pipe_busy | ctl_pipe_ff[i].valid;
      end
   end

   // t advances by 2^16/n, carrying the remainder
   assign r_sum = {1'b0, r_ff} + {1'b0, remd_ff};

   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      quot_in = quot_ff;
      remd_in = remd_ff;
      k_in = k_ff;
      t_in = t_ff;
      r_in = r_ff;
      q_pop = 1'b0;
      issue.valid = 1'b0;
      issue.last = (k_ff == n_ff);
      unique case (state_ff)
         cbs_pkg::BACK_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               n_in = q_head.n;
               quot_in = q_head.quot;
               remd_in = q_head.remd;
               k_in = '0;
               t_in = '0;
               r_in = '0;
               state_in = cbs_pkg::BACK_RUN;
            end
         end
         cbs_pkg::BACK_RUN: begin
            issue.valid = 1'b1;
            k_in = k_ff + 1'b1;
            if (r_sum >= {1'b0, n_ff}) begin
               r_in = cbs_pkg::CNT_BITS'(r_sum - {1'b0, n_ff});
               t_in = t_ff + quot_ff + 1'b1;
            end else begin
               r_in = cbs_pkg::CNT_BITS'(r_sum);
               t_in = t_ff + quot_ff;
            end
            if (k_ff == n_ff) begin
               state_in = cbs_pkg::BACK_DRAIN;
            end
         end
         cbs_pkg::BACK_DRAIN: begin
            if (!pipe_busy) begin
               state_in = cbs_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = cbs_pkg::BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbs_pkg::BACK_IDLE;
         for (int i = 0; i < cbs_pkg::PIPE_DEPTH; i++) begin
            ctl_pipe_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ctl_pipe_ff[0] <= issue;
         for (int i = 1; i < cbs_pkg::PIPE_DEPTH; i++) begin
            ctl_pipe_ff[i] <= ctl_pipe_ff[i-1];
         end
      end
      n_ff <= n_in;
      quot_ff <= quot_in;
      remd_ff <= remd_in;
      k_ff <= k_in;
      t_ff <= t_in;
      r_ff <= r_in;
   end

   // x and y datapaths
   cbs_lane u_lane_x (
      .clock   (clock),
      .load    (q_pop),
      .p0      (q_head.p0_x),
      .c0      (q_head.c0_x),
      .c1      (q_head.c1_x),
      .p1      (q_head.p1_x),
      .t       (t_ff),
      .last_s5 (ctl_pipe_ff[cbs_pkg::PIPE_DEPTH-2].last),
      .point   (rsp_point_x)
   );

   cbs_lane u_lane_y (
      .clock   (clock),
      .load    (q_pop),
      .p0      (q_head.p0_y),
      .c0      (q_head.c0_y),
      .c1      (q_head.c1_y),
      .p1      (q_head.p1_y),
      .t       (t_ff),
      .last_s5 (ctl_pipe_ff[cbs_pkg::PIPE_DEPTH-2].last),
      .point   (rsp_point_y)
   );

   assign rsp_strobe = ctl_pipe_ff[cbs_pkg::PIPE_DEPTH-1].valid;
   assign rsp_last_point = ctl_pipe_ff[cbs_pkg::PIPE_DEPTH-1].last;

   // remainder of the t step stays below n while points are issued
   a_rem_below_n: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbs_pkg::BACK_RUN) |-> (r_ff < n_ff))
      else $error("t remainder out of range");

   // new coefficients only once the lanes hold no point of the old segment
   a_load_drained: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !pipe_busy)
      else $error("segment loaded over points in flight");

   // the final point of a segment ends the issue phase
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (issue.valid && issue.last) |=> (state_ff == cbs_pkg::BACK_DRAIN))
      else $error("points issued past the final one");

   // a segment's final point is never directly followed by another point
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_point) |=> !rsp_strobe)
      else $error("point right after final point");

endmodule

FILE: hw/rtl/cubic_bezier_sampler.sv
// the 17-step divider for 2^16/n sets the lead-in: after it the segment passes the queue and
//    the lanes, and its points come out one per cycle, n+1 points in all
// busy is high while dividing and until the push (longer while the 2-entry queue is full);
//    the back end pops the next segment after the n+1 points and the lane drain
// the receiver cannot stall: each point is shown for one cycle on rsp_strobe
// reset: synchronous, clears both sequencers, the queue and the point pipeline; no clear pass
module cubic_bezier_sampler (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  cbs_pkg::coord_type  req_start_x,
   input  cbs_pkg::coord_type  req_start_y,
   input  cbs_pkg::coord_type  req_ctrl_a_x,
   input  cbs_pkg::coord_type  req_ctrl_a_y,
   input  cbs_pkg::coord_type  req_ctrl_b_x,
   input  cbs_pkg::coord_type  req_ctrl_b_y,
   input  cbs_pkg::coord_type  req_end_x,
   input  cbs_pkg::coord_type  req_end_y,
   input  cbs_pkg::count_type  req_sample_count,
   output logic                rsp_strobe,
   output cbs_pkg::coord_type  rsp_point_x,
   output cbs_pkg::coord_type  rsp_point_y,
   output logic                rsp_last_point
);

   cbs_pkg::qstat_type q_stat;
   cbs_pkg::seg_type q_wdata;
   cbs_pkg::seg_type q_rdata;
   logic q_push;
   logic q_pop;

   // segment intake and step division
   cbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_ctrl_a_x     (req_ctrl_a_x),
      .req_ctrl_a_y     (req_ctrl_a_y),
      .req_ctrl_b_x     (req_ctrl_b_x),
      .req_ctrl_b_y     (req_ctrl_b_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_sample_count (req_sample_count),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   // segment queue between intake and evaluation
   cbs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // point sequencing and curve evaluation
   cbs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_stat         (q_stat),
      .q_head         (q_rdata),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

endmodule
